FILE: hw/rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Field widths, operation codes and the tag that follows each
// multiply-accumulate step down the datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int SIZE_W = 4;

  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;     // first term of a dot product
    logic             last_k;    // final term of a dot product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_col;  // dot product closes the row
  } imm_tag_t;

endpackage

FILE: hw/rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Holds the left and right matrices in two synchronous memories; a shared MAC
// emits one product row per compute item whose row is below the active size.
// ----------------------------------------------------------------------------
// A compute item of size N issues N*N memory reads through the single MAC,
// one per cycle while no stalled result holds the datapath, then drains the
// read, multiply and accumulate stages before a new item is taken. A stalled
// result holds the whole datapath. Reset clears control state and sets the
// active size to 8; matrix contents are undefined until written.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
  import imm_pkg::*;
#(
  parameter int DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration
  input  logic                    cfg_wen,
  input  logic [SIZE_W-1:0]       cfg_wdata,
  // Input items
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [OP_W-1:0]         operation,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] element_value,
  // Result items
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [IDX_W-1:0]        result_row,
  output logic [IDX_W-1:0]        result_col,
  output logic signed [ACC_W-1:0] product_value,
  output logic                    last_in_row
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);

  logic [SIZE_W-1:0]       active_size;
  logic [SIZE_W-1:0]       eff_size;
  logic [SIZE_W-1:0]       size_m1;
  logic                    issuing;
  logic [IW-1:0]           j_cnt;
  logic [IW-1:0]           k_cnt;
  logic [IDX_W-1:0]        row;
  logic                    k_end;
  logic                    j_end;
  logic                    adv;
  logic                    busy;
  logic                    item_xfer;
  logic                    in_range;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           left_addr;
  logic [AW-1:0]           right_addr;
  logic [VAL_W-1:0]        left_mem  [DEPTH];
  logic [VAL_W-1:0]        right_mem [DEPTH];
  logic signed [VAL_W-1:0] left_rd;
  logic signed [VAL_W-1:0] right_rd;
  imm_tag_t                issue_tag;
  imm_tag_t                rd_tag;
  imm_tag_t                mac_tag;
  logic signed [ACC_W-1:0] mac_sum;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_RESET;
    end else if (cfg_wen) begin
      active_size <= cfg_wdata;
    end
  end

  // Size in use: zero counts as one, and it never exceeds the built dimension.
  always_comb begin
    eff_size = active_size;
    if (active_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(active_size) > DIM) begin
      eff_size = SIZE_W'(DIM);
    end
  end

  // The whole datapath holds while a finished result waits to be taken.
  assign adv        = !(result_valid && result_stall);
  assign busy       = issuing || rd_tag.valid || mac_tag.valid;
  assign item_stall = busy;
  assign item_xfer  = item_valid && !item_stall;

  // Loads outside the stored matrix are dropped.
  assign in_range = (32'(row_index) < DIM) && (32'(col_index) < DIM);
  assign wr_addr  = AW'(row_index) * AW'(DIM) + AW'(col_index);

  // Read sequencer: k runs fastest, one column per dot product.
  assign k_end = (32'(k_cnt) == 32'(size_m1));
  assign j_end = (32'(j_cnt) == 32'(size_m1));

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
    end else if (item_xfer && operation == OP_COMPUTE
                 && 32'(row_index) < 32'(eff_size)) begin
      issuing <= 1'b1;
    end else if (issuing && adv && k_end && j_end) begin
      issuing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      j_cnt   <= '0;
      k_cnt   <= '0;
      row     <= row_index;
      size_m1 <= eff_size - SIZE_W'(1);
    end else if (issuing && adv) begin
      if (k_end) begin
        k_cnt <= '0;
        j_cnt <= j_cnt + IW'(1);
      end else begin
        k_cnt <= k_cnt + IW'(1);
      end
    end
  end

  assign left_addr  = AW'(row) * AW'(DIM) + AW'(k_cnt);
  assign right_addr = AW'(k_cnt) * AW'(DIM) + AW'(j_cnt);

  always_comb begin
    issue_tag.valid    = issuing;
    issue_tag.first    = (k_cnt == '0);
    issue_tag.last_k   = k_end;
    issue_tag.row      = row;
    issue_tag.col      = IDX_W'(j_cnt);
    issue_tag.last_col = j_end;
  end

  // Left matrix memory.
  always_ff @(posedge clk) begin
    if (item_xfer && operation == OP_LOAD_LEFT && in_range) begin
      left_mem[wr_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_rd <= left_mem[left_addr];
    end
  end

  // Right matrix memory.
  always_ff @(posedge clk) begin
    if (item_xfer && operation == OP_LOAD_RIGHT && in_range) begin
      right_mem[wr_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      right_rd <= right_mem[right_addr];
    end
  end

  // Tag for the read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else if (adv) begin
      rd_tag <= issue_tag;
    end
  end

  imm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (rd_tag),
    .a       (left_rd),
    .b       (right_rd),
    .tag_out (mac_tag),
    .sum     (mac_sum)
  );

  // Output register: loads a finished dot product, clears on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && mac_tag.valid && mac_tag.last_k) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mac_tag.valid && mac_tag.last_k) begin
      result_row    <= mac_tag.row;
      result_col    <= mac_tag.col;
      product_value <= mac_sum;
      last_in_row   <= mac_tag.last_col;
    end
  end

endmodule

FILE: hw/rtl/imm_mac.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply MAC
// Registered 16x16 signed multiply followed by a 40-bit accumulator. The sum
// of the current step is presented combinationally so that the caller can
// capture a finished dot product in the same cycle.
// ----------------------------------------------------------------------------
module imm_mac
  import imm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  imm_tag_t                tag_in,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output imm_tag_t                tag_out,
  output logic signed [ACC_W-1:0] sum
);

  imm_tag_t                 p_tag;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
    end else if (adv) begin
      p_tag <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // Accumulate; the first term of a dot product restarts the sum.
  always_comb begin
    sum = (p_tag.first ? ACC_W'(0) : acc) + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (adv && p_tag.valid) begin
      acc <= sum;
    end
  end

  assign tag_out = p_tag;

endmodule
